/* rtl/jdcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jdcd_pkg
// Shared constants and the day-offset table for the Julian Day to calendar
// date unit.
// ----------------------------------------------------------------------------
package jdcd_pkg;

    localparam int FRACTION_BITS_DEF = 24;
    localparam int DAY_BITS_DEF      = 23;

    // pipeline depth of the date path (after the half-day stage) and time path
    localparam int DATE_STAGES = 9;
    localparam int TIME_STAGES = 3;

    localparam int unsigned GREGORIAN_START = 2299161;
    localparam int unsigned ALPHA_OFFSET    = 7468865;
    localparam longint unsigned ALPHA_DIV   = 146097;
    localparam int unsigned B_OFFSET        = 1524;
    localparam int unsigned C_SCALE         = 20;
    localparam int unsigned C_OFFSET        = 2442;
    localparam longint unsigned C_DIV       = 7305;
    localparam int unsigned D_MUL           = 1461;
    localparam longint unsigned E_MUL       = 10000;
    localparam longint unsigned E_DIV       = 306001;
    localparam int unsigned YEAR_OFS_LATE   = 4716;
    localparam int unsigned YEAR_OFS_EARLY  = 4715;
    localparam int unsigned MONTH_WRAP      = 14;

    // width of B - D, which always lies in 123..488
    localparam int BD_BITS = 9;
    localparam int E_BITS  = 4;

    // floor(30.6001 * e)
    function automatic logic [BD_BITS-1:0] month_offset(input logic [E_BITS-1:0] e);
        logic [BD_BITS-1:0] v;
        unique case (e)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            default: v = 9'd459;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/julian_day_to_calendar_date_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_unit
// Converts a Julian Day (whole days plus binary day fraction) to calendar
// year, month, day and truncated hour, minute, second.
//
//   channel   handshake           payload
//   --------  ------------------  ---------------------------------------
//   input     start / busy        i_jd_whole_days, i_jd_day_fraction
//   result    o_valid strobe      o_cal_year .. o_cal_second
//
// One beat per cycle in while busy is low, one result beat per input, strobed
// after the half-day stage and the date path registers; depth set by the three
// reciprocal multipliers of the date path, each with its own stage. busy is high
// only while in reset and until the first clock edge after release; results
// cannot be held off and the pipe never stalls.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_unit #(
    parameter int FRACTION_BITS = jdcd_pkg::FRACTION_BITS_DEF,
    parameter int DAY_BITS      = jdcd_pkg::DAY_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [DAY_BITS-1:0]      i_jd_whole_days,
    input  wire logic [FRACTION_BITS-1:0] i_jd_day_fraction,
    output logic                          o_valid,
    output logic signed [15:0]            o_cal_year,
    output logic [3:0]                    o_cal_month,
    output logic [4:0]                    o_cal_day,
    output logic [4:0]                    o_cal_hour,
    output logic [5:0]                    o_cal_minute,
    output logic [5:0]                    o_cal_second
);

    localparam int FB  = FRACTION_BITS;
    localparam int PAD = jdcd_pkg::DATE_STAGES - jdcd_pkg::TIME_STAGES;
    localparam logic [FB:0] HALF_DAY = (FB+1)'(1) << (FB-1);

    logic            r_ready;
    logic            r_s1_vld;
    logic [DAY_BITS:0] r_s1_z;
    logic [FB-1:0]   r_s1_f;
    logic [FB:0]     n_t;
    logic            n_acc;

    logic [4:0]      w_hour;
    logic [5:0]      w_minute;
    logic [5:0]      w_second;
    logic [16:0]     r_pad [PAD];

    assign busy  = !r_ready;
    assign n_acc = start && r_ready;
    assign n_t   = {1'b0, i_jd_day_fraction} + HALF_DAY;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_s1_vld <= 1'b0;
        end else begin
            r_ready  <= 1'b1;
            r_s1_vld <= n_acc;
        end
    end

    // half-day shift, carry into the day number
    always_ff @(posedge i_clk) begin
        r_s1_z <= (DAY_BITS+1)'(i_jd_whole_days) + (DAY_BITS+1)'(n_t[FB]);
        r_s1_f <= n_t[FB-1:0];
    end

    jdcd_date #(
        .DAY_BITS (DAY_BITS)
    ) u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s1_vld),
        .i_z     (r_s1_z),
        .o_vld   (o_valid),
        .o_year  (o_cal_year),
        .o_month (o_cal_month),
        .o_day   (o_cal_day)
    );

    jdcd_time #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_time (
        .i_clk    (i_clk),
        .i_f      (r_s1_f),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_second (w_second)
    );

    // align time of day with the longer date path
    always_ff @(posedge i_clk) begin
        r_pad[0] <= {w_hour, w_minute, w_second};
        for (int i = 1; i < PAD; i++) begin
            r_pad[i] <= r_pad[i-1];
        end
    end

    assign o_cal_hour   = r_pad[PAD-1][16:12];
    assign o_cal_minute = r_pad[PAD-1][11:6];
    assign o_cal_second = r_pad[PAD-1][5:0];

endmodule
`default_nettype wire

/* rtl/jdcd_time.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jdcd_time
// Three-stage split of a day fraction into hour, minute and second by
// truncating multiplications by 24, 60 and 60.
// ----------------------------------------------------------------------------
module jdcd_time #(
    parameter int FRACTION_BITS = jdcd_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic [FRACTION_BITS-1:0] i_f,
    output logic [4:0]                    o_hour,
    output logic [5:0]                    o_minute,
    output logic [5:0]                    o_second
);

    localparam int FB = FRACTION_BITS;

    logic [FB+4:0] n_p1;
    logic [FB+5:0] n_p2;
    logic [FB+5:0] n_p3;

    logic [4:0]    r_s1_h;
    logic [FB-1:0] r_s1_r;
    logic [4:0]    r_s2_h;
    logic [5:0]    r_s2_m;
    logic [FB-1:0] r_s2_r;
    logic [4:0]    r_s3_h;
    logic [5:0]    r_s3_m;
    logic [5:0]    r_s3_s;

    always_comb begin
        n_p1 = (FB+5)'(i_f) * (FB+5)'(24);
        n_p2 = (FB+6)'(r_s1_r) * (FB+6)'(60);
        n_p3 = (FB+6)'(r_s2_r) * (FB+6)'(60);
    end

    always_ff @(posedge i_clk) begin
        r_s1_h <= n_p1[FB+4:FB];
        r_s1_r <= n_p1[FB-1:0];
        r_s2_h <= r_s1_h;
        r_s2_m <= n_p2[FB+5:FB];
        r_s2_r <= n_p2[FB-1:0];
        r_s3_h <= r_s2_h;
        r_s3_m <= r_s2_m;
        r_s3_s <= n_p3[FB+5:FB];
    end

    assign o_hour   = r_s3_h;
    assign o_minute = r_s3_m;
    assign o_second = r_s3_s;

endmodule
`default_nettype wire

/* rtl/jdcd_date.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jdcd_date
// Nine-stage pipeline from whole day number to year, month and day; the
// constant divisions are exact reciprocal multiplications.
// ----------------------------------------------------------------------------
module jdcd_date #(
    parameter int DAY_BITS = jdcd_pkg::DAY_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic [DAY_BITS:0] i_z,
    output logic                   o_vld,
    output logic signed [15:0]     o_year,
    output logic [3:0]             o_month,
    output logic [4:0]             o_day
);

    localparam int ZW  = DAY_BITS + 1;
    localparam int XW  = DAY_BITS + 3;
    localparam int SA  = XW + 18;
    localparam int MAW = XW + 1;
    localparam int PAW = XW + MAW;
    localparam int AW  = PAW - SA;
    localparam longint unsigned MA_L =
        ((64'd1 << SA) + jdcd_pkg::ALPHA_DIV - 64'd1) / jdcd_pkg::ALPHA_DIV;
    localparam logic [MAW-1:0] MA = MAW'(MA_L);

    localparam int BW  = DAY_BITS + 1;
    localparam int XCW = DAY_BITS + 6;
    localparam int SC  = XCW + 13;
    localparam int MCW = XCW + 1;
    localparam int PCW = XCW + MCW;
    localparam int CW  = PCW - SC;
    localparam longint unsigned MC_L =
        ((64'd1 << SC) + jdcd_pkg::C_DIV - 64'd1) / jdcd_pkg::C_DIV;
    localparam logic [MCW-1:0] MC = MCW'(MC_L);

    localparam int BDW = jdcd_pkg::BD_BITS;
    localparam int EW  = jdcd_pkg::E_BITS;
    localparam int SE  = BDW + 19;
    localparam int MEW = SE - 4;
    localparam int PEW = BDW + MEW;
    localparam longint unsigned ME_L =
        ((jdcd_pkg::E_MUL << SE) + jdcd_pkg::E_DIV - 64'd1) / jdcd_pkg::E_DIV;
    localparam logic [MEW-1:0] ME = MEW'(ME_L);

    localparam int NS = jdcd_pkg::DATE_STAGES;

    logic [NS-1:0] r_vld;

    logic          r_s2_greg;
    logic [XW-1:0] r_s2_x;
    logic [ZW-1:0] r_s2_z;

    logic           r_s3_greg;
    logic [PAW-1:0] r_s3_pa;
    logic [ZW-1:0]  r_s3_z;

    logic [BW-1:0]  n_s4_b;
    logic [AW-1:0]  n_alpha;
    logic [BW-1:0]  r_s4_b;

    logic [XCW-1:0] r_s5_xc;
    logic [BW-1:0]  r_s5_b;

    logic [PCW-1:0] r_s6_pc;
    logic [BW-1:0]  r_s6_b;

    logic [CW-1:0]  r_s7_c;
    logic [BW-1:0]  r_s7_b;

    logic [CW+10:0] n_dprod;
    logic [BDW-1:0] r_s8_bd;
    logic [15:0]    r_s8_c;

    logic [PEW-1:0] r_s9_pe;
    logic [BDW-1:0] r_s9_bd;
    logic [15:0]    r_s9_c;

    logic [EW-1:0]  n_e;
    logic [3:0]     n_month;
    logic [15:0]    n_year;
    logic [BDW-1:0] n_day;

    logic [15:0]    r_s10_year;
    logic [3:0]     r_s10_month;
    logic [4:0]     r_s10_day;

    always_comb begin
        n_alpha = r_s3_pa[PAW-1:SA];
        if (r_s3_greg) begin
            n_s4_b = BW'(r_s3_z) + BW'(1) + BW'(n_alpha) - BW'(n_alpha >> 2)
                   + BW'(jdcd_pkg::B_OFFSET);
        end else begin
            n_s4_b = BW'(r_s3_z) + BW'(jdcd_pkg::B_OFFSET);
        end

        n_dprod = (CW+11)'(r_s7_c) * (CW+11)'(jdcd_pkg::D_MUL);

        n_e = r_s9_pe[SE+EW-1:SE];
        if (n_e < EW'(jdcd_pkg::MONTH_WRAP)) begin
            n_month = n_e - 4'd1;
        end else begin
            n_month = n_e - 4'd13;
        end
        if (n_month > 4'd2) begin
            n_year = r_s9_c - 16'(jdcd_pkg::YEAR_OFS_LATE);
        end else begin
            n_year = r_s9_c - 16'(jdcd_pkg::YEAR_OFS_EARLY);
        end
        n_day = r_s9_bd - jdcd_pkg::month_offset(n_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_greg <= (i_z >= ZW'(jdcd_pkg::GREGORIAN_START));
        r_s2_x    <= {i_z, 2'b00} - XW'(jdcd_pkg::ALPHA_OFFSET);
        r_s2_z    <= i_z;

        r_s3_greg <= r_s2_greg;
        r_s3_pa   <= PAW'(r_s2_x) * PAW'(MA);
        r_s3_z    <= r_s2_z;

        r_s4_b    <= n_s4_b;

        r_s5_xc   <= XCW'(r_s4_b) * XCW'(jdcd_pkg::C_SCALE) - XCW'(jdcd_pkg::C_OFFSET);
        r_s5_b    <= r_s4_b;

        r_s6_pc   <= PCW'(r_s5_xc) * PCW'(MC);
        r_s6_b    <= r_s5_b;

        r_s7_c    <= r_s6_pc[PCW-1:SC];
        r_s7_b    <= r_s6_b;

        // only the low bits of b - d matter, the true value is below 512
        r_s8_bd   <= r_s7_b[BDW-1:0] - n_dprod[BDW+1:2];
        r_s8_c    <= r_s7_c[15:0];

        r_s9_pe   <= PEW'(r_s8_bd) * PEW'(ME);
        r_s9_bd   <= r_s8_bd;
        r_s9_c    <= r_s8_c;

        r_s10_year  <= n_year;
        r_s10_month <= n_month;
        r_s10_day   <= n_day[4:0];
    end

    assign o_vld   = r_vld[NS-1];
    assign o_year  = r_s10_year;
    assign o_month = r_s10_month;
    assign o_day   = r_s10_day;

endmodule
`default_nettype wire

/* sim/tb_julian_day_to_calendar_date_unit.sv */
// ----------------------------------------------------------------------------
// tb_julian_day_to_calendar_date_unit
// Self-checking bench for the Julian Day to calendar date unit. A driver feeds
// input beats from a backlog filled with directed corner cases and random
// days. A monitor predicts year, month, day and truncated time of day for each
// accepted beat and checks every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_julian_day_to_calendar_date_unit;

    localparam int FRACTION_BITS = jdcd_pkg::FRACTION_BITS_DEF;
    localparam int DAY_BITS      = jdcd_pkg::DAY_BITS_DEF;
    localparam int RANDOM_DAYS   = 1500;
    localparam int QUIET_LIMIT   = 400;
    localparam int DRAIN_CYCLES  = 30;
    localparam int REPORT_LIMIT  = 10;

    localparam longint unsigned HALF_DAY  = 64'd1 << (FRACTION_BITS - 1);
    localparam longint unsigned FRAC_MASK = (64'd1 << FRACTION_BITS) - 1;

    typedef struct packed {
        logic [DAY_BITS-1:0]      whole_days;
        logic [FRACTION_BITS-1:0] day_fraction;
    } t_jd_beat;

    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
    } t_cal_date;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [DAY_BITS-1:0]      i_jd_whole_days = '0;
    logic [FRACTION_BITS-1:0] i_jd_day_fraction = '0;
    logic                     o_valid;
    logic signed [15:0]       o_cal_year;
    logic [3:0]               o_cal_month;
    logic [4:0]               o_cal_day;
    logic [4:0]               o_cal_hour;
    logic [5:0]               o_cal_minute;
    logic [5:0]               o_cal_second;

    t_jd_beat  jd_backlog[$];
    t_cal_date dates_due[$];
    logic      in_beat = 1'b0;
    int        beats_offered = 0;
    int        fault_count = 0;
    int        quiet_cycles = 0;
    bit        run_over = 1'b0;

    julian_day_to_calendar_date_unit #(
        .FRACTION_BITS (FRACTION_BITS),
        .DAY_BITS      (DAY_BITS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_jd_whole_days   (i_jd_whole_days),
        .i_jd_day_fraction (i_jd_day_fraction),
        .o_valid           (o_valid),
        .o_cal_year        (o_cal_year),
        .o_cal_month       (o_cal_month),
        .o_cal_day         (o_cal_day),
        .o_cal_hour        (o_cal_hour),
        .o_cal_minute      (o_cal_minute),
        .o_cal_second      (o_cal_second)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_cal_date jd_to_calendar(input logic [DAY_BITS-1:0] whole_days,
                                                 input logic [FRACTION_BITS-1:0] day_fraction);
        longint unsigned shifted, z, f, a, alpha, b, c, d, bd, e, mon, yr, rem, hr, mn, sc;
        t_cal_date r;
        shifted = day_fraction;
        shifted = shifted + HALF_DAY;
        z = whole_days;
        z = z + (shifted >> FRACTION_BITS);
        f = shifted & FRAC_MASK;
        a = z;
        if (z >= jdcd_pkg::GREGORIAN_START) begin
            alpha = (4 * z - 7468865) / 146097;
            a = z + 1 + alpha - alpha / 4;
        end
        b = a + 1524;
        c = (20 * b - 2442) / 7305;
        d = (1461 * c) / 4;
        bd = b - d;
        e = (10000 * bd) / 306001;
        mon = (e < 14) ? e - 1 : e - 13;
        yr = (mon > 2) ? c - 4716 : c - 4715;
        rem = f * 24;
        hr = rem >> FRACTION_BITS;
        rem = (rem & FRAC_MASK) * 60;
        mn = rem >> FRACTION_BITS;
        rem = (rem & FRAC_MASK) * 60;
        sc = rem >> FRACTION_BITS;
        r.year   = yr[15:0];
        r.month  = mon[3:0];
        r.day    = 5'(bd - (306001 * e) / 10000);
        r.hour   = hr[4:0];
        r.minute = mn[5:0];
        r.second = sc[5:0];
        return r;
    endfunction

    task automatic queue_jd(input int unsigned whole_days, input int unsigned day_fraction);
        t_jd_beat b;
        b.whole_days   = whole_days[DAY_BITS-1:0];
        b.day_fraction = day_fraction[FRACTION_BITS-1:0];
        jd_backlog.push_back(b);
    endtask

    // driver: new beat only once the current one has gone in
    always @(negedge i_clk) begin : drive_beats
        t_jd_beat nxt;
        bit       hold_off;
        if (!start || in_beat) begin
            hold_off = ($urandom_range(0, 99) < 6) &&
                       !(beats_offered >= 600 && beats_offered < 1000);
            if (jd_backlog.size() == 0 || hold_off) begin
                start <= 1'b0;
            end else begin
                nxt = jd_backlog.pop_front();
                start             <= 1'b1;
                i_jd_whole_days   <= nxt.whole_days;
                i_jd_day_fraction <= nxt.day_fraction;
                beats_offered++;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_cal_date got, want;
        in_beat <= start && !busy;
        if (start && !busy)
            dates_due.push_back(jd_to_calendar(i_jd_whole_days, i_jd_day_fraction));
        if (o_valid) begin
            got = '{year: o_cal_year, month: o_cal_month, day: o_cal_day,
                    hour: o_cal_hour, minute: o_cal_minute, second: o_cal_second};
            if (dates_due.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result beat: %0d-%0d-%0d %0d:%0d:%0d",
                             got.year, got.month, got.day, got.hour, got.minute, got.second);
            end else begin
                want = dates_due.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $write("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d",
                               want.year, want.month, want.day,
                               want.hour, want.minute, want.second);
                        $display(", got %0d-%0d-%0d %0d:%0d:%0d",
                                 got.year, got.month, got.day,
                                 got.hour, got.minute, got.second);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT && !run_over) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : run_sequence
        int          pick;
        int unsigned whole, frac;
        // field extremes and half-day carry
        queue_jd(0, 0);
        queue_jd(0, 24'hFFFFFF);
        queue_jd(0, 24'h800000);
        queue_jd(0, 24'h7FFFFF);
        queue_jd(0, 24'h400000);
        queue_jd(1, 1);
        queue_jd(23'h7FFFFF, 0);
        queue_jd(23'h7FFFFF, 24'hFFFFFF);
        queue_jd(23'h555555, 24'hAAAAAA);
        queue_jd(23'h2AAAAA, 24'h555555);
        // either side of the calendar reform
        queue_jd(2299160, 24'h7FFFFF);
        queue_jd(2299160, 24'h800000);
        queue_jd(2299161, 0);
        queue_jd(2299159, 24'hC00000);
        // year, month and leap-day edges
        queue_jd(1721423, 24'h800000);
        queue_jd(1721057, 24'h800000);
        queue_jd(2415079, 24'h800000);
        queue_jd(2451544, 24'h800000);
        queue_jd(2451545, 0);
        queue_jd(2451603, 24'h800000);
        queue_jd(2451604, 24'h800000);
        queue_jd(2451910, 24'h7FFFFF);
        queue_jd(2460000, 24'hFFFFFF);
        for (int n = 0; n < RANDOM_DAYS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                whole = $urandom_range(0, 23'h7FFFFF);
            else if (pick < 70)
                whole = jdcd_pkg::GREGORIAN_START - 20 + $urandom_range(0, 40);
            else if (pick < 88)
                whole = $urandom_range(2400000, 2500000);
            else
                whole = $urandom_range(0, 2000);
            if ($urandom_range(0, 9) == 0)
                frac = 24'h800000 - 4 + $urandom_range(0, 8);
            else
                frac = $urandom_range(0, 24'hFFFFFF);
            queue_jd(whole, frac);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (jd_backlog.size() != 0 || start || dates_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        run_over = 1'b1;

        if (fault_count == 0 && dates_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
